// File: rtl/nne_pkg.sv
// ----------------------------------------------------------------------------
// nne_pkg
// Shared types, codes and decode for the netlist node evaluator.
// ----------------------------------------------------------------------------
package nne_pkg;

    localparam int NNE_DEFAULT_DEPTH = 1024;
    localparam int NNE_WORD_W        = 32;
    localparam int NNE_REF_W         = 11;
    localparam int NNE_NUM_REFS      = 9;

    localparam logic [31:0] DISC_WORD = 32'hFFFF_0000;
    localparam logic [31:0] BIT_MASK  = 32'h0001_0001;

    // request action codes
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_EVAL  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // node kinds
    localparam logic [3:0] OP_NAND   = 4'd1;
    localparam logic [3:0] OP_TRI    = 4'd2;
    localparam logic [3:0] OP_SPLIT4 = 4'd3;
    localparam logic [3:0] OP_SPLIT8 = 4'd4;
    localparam logic [3:0] OP_MERGE4 = 4'd5;
    localparam logic [3:0] OP_MERGE8 = 4'd6;
    localparam logic [3:0] OP_M4TO8  = 4'd7;
    localparam logic [3:0] OP_S8TO4  = 4'd8;
    localparam logic [3:0] OP_BUS    = 4'd9;

    typedef enum logic [3:0] {
        K_NONE,
        K_NAND,
        K_TRI,
        K_SPLIT,
        K_MERGE,
        K_M4TO8,
        K_S8TO4,
        K_COPY,
        K_LOAD
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_WRITE,
        ST_RESP
    } state_t;

    typedef struct packed {
        kind_t      kind;
        logic       bad;
        logic       rd_en;
        logic [3:0] rd_last;
        logic       wr_en;
        logic [3:0] wr_first;
        logic [3:0] wr_last;
    } plan_t;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] slot;
        logic [3:0] rd_last;
        logic [3:0] wr_last;
    } alu_ctl_t;

    // which slots a request reads and writes, and how the words combine
    function automatic plan_t plan_of(input logic [1:0] action, input logic [3:0] op);
        plan_t p;
        p = '{kind: K_NONE, bad: 1'b0, rd_en: 1'b0, rd_last: 4'd0,
              wr_en: 1'b0, wr_first: 4'd0, wr_last: 4'd0};
        unique case (action)
            ACT_WRITE:
            begin
                p.kind  = K_COPY;
                p.wr_en = 1'b1;
            end
            ACT_READ:
            begin
                p.kind  = K_LOAD;
                p.rd_en = 1'b1;
            end
            ACT_EVAL:
            begin
                p.rd_en = 1'b1;
                p.wr_en = 1'b1;
                unique case (op)
                    OP_NAND:
                    begin
                        p.kind = K_NAND; p.rd_last = 4'd1;
                        p.wr_first = 4'd2; p.wr_last = 4'd2;
                    end
                    OP_TRI:
                    begin
                        p.kind = K_TRI; p.rd_last = 4'd1;
                        p.wr_first = 4'd2; p.wr_last = 4'd2;
                    end
                    OP_SPLIT4:
                    begin
                        p.kind = K_SPLIT; p.rd_last = 4'd0;
                        p.wr_first = 4'd1; p.wr_last = 4'd4;
                    end
                    OP_SPLIT8:
                    begin
                        p.kind = K_SPLIT; p.rd_last = 4'd0;
                        p.wr_first = 4'd1; p.wr_last = 4'd8;
                    end
                    OP_MERGE4:
                    begin
                        p.kind = K_MERGE; p.rd_last = 4'd3;
                        p.wr_first = 4'd4; p.wr_last = 4'd4;
                    end
                    OP_MERGE8:
                    begin
                        p.kind = K_MERGE; p.rd_last = 4'd7;
                        p.wr_first = 4'd8; p.wr_last = 4'd8;
                    end
                    OP_M4TO8:
                    begin
                        p.kind = K_M4TO8; p.rd_last = 4'd1;
                        p.wr_first = 4'd2; p.wr_last = 4'd2;
                    end
                    OP_S8TO4:
                    begin
                        p.kind = K_S8TO4; p.rd_last = 4'd0;
                        p.wr_first = 4'd1; p.wr_last = 4'd2;
                    end
                    OP_BUS:
                    begin
                        p.kind = K_COPY; p.rd_last = 4'd0;
                        p.wr_first = 4'd1; p.wr_last = 4'd1;
                    end
                    default:
                    begin
                        p.bad   = 1'b1;
                        p.rd_en = 1'b0;
                        p.wr_en = 1'b0;
                    end
                endcase
            end
            default:
            begin
                p.kind = K_NONE;
            end
        endcase
        return p;
    endfunction

endpackage

// File: rtl/nne_store.sv
// ----------------------------------------------------------------------------
// nne_store
// Single-port signal word store with registered read data.
// ----------------------------------------------------------------------------
module nne_store
    import nne_pkg::*;
#(
    parameter int DEPTH = NNE_DEFAULT_DEPTH,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic                  we,
    input  logic [AW-1:0]         addr,
    input  logic [NNE_WORD_W-1:0] wdata,
    output logic [NNE_WORD_W-1:0] rdata
);

    logic [NNE_WORD_W-1:0] mem_reg [DEPTH];
    logic [NNE_WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/nne_alu.sv
// ----------------------------------------------------------------------------
// nne_alu
// Shared word unit: folds operand words in and forms each result word.
// ----------------------------------------------------------------------------
module nne_alu
    import nne_pkg::*;
(
    input  alu_ctl_t              ctl,
    input  logic [NNE_WORD_W-1:0] op_a,
    input  logic [NNE_WORD_W-1:0] op_b,
    input  logic [NNE_WORD_W-1:0] acc,
    input  logic [NNE_WORD_W-1:0] rd_word,
    output logic [NNE_WORD_W-1:0] acc_next,
    output logic [NNE_WORD_W-1:0] wr_word
);

    logic [3:0] place_pos;
    logic [3:0] pick_pos;

    // merge: operand in slot k lands at bit (last read slot - k)
    assign place_pos = ctl.rd_last - ctl.slot;
    assign acc_next  = acc | ((rd_word & BIT_MASK) << place_pos[2:0]);

    // split: result in slot k takes bit (last write slot - k)
    assign pick_pos = ctl.wr_last - ctl.slot;

    always_comb
    begin
        wr_word = '0;
        unique case (ctl.kind)
            K_NAND:
            begin
                wr_word = {31'b0, ~(op_a[0] & op_b[0])};
            end
            K_TRI:
            begin
                wr_word = op_b[0] ? op_a : DISC_WORD;
            end
            K_SPLIT:
            begin
                wr_word = (op_a >> pick_pos[2:0]) & BIT_MASK;
            end
            K_MERGE:
            begin
                wr_word = acc;
            end
            K_M4TO8:
            begin
                wr_word = {8'b0, op_a[19:16], op_b[19:16],
                           op_b[15:0] | {op_a[11:0], 4'b0}};
            end
            K_S8TO4:
            begin
                // high nibbles go to the first output slot
                if (ctl.slot == ctl.wr_last)
                begin
                    wr_word = {12'b0, op_a[19:16], 12'b0, op_a[3:0]};
                end
                else
                begin
                    wr_word = {12'b0, op_a[23:20], 12'b0, op_a[7:4]};
                end
            end
            K_COPY, K_LOAD:
            begin
                wr_word = op_a;
            end
            default:
            begin
                wr_word = '0;
            end
        endcase
    end

endmodule

// File: rtl/netlist_node_evaluator_unit.sv
// ----------------------------------------------------------------------------
// netlist_node_evaluator_unit
// Gate-level node evaluator over a store of 32-bit signal words.
//
//   channel   direction  handshake             payload
//   request   in         req_valid/req_stall   action, node_op, ref_0..ref_8,
//                                               write_value
//   result    out        res_valid/res_stall   read_data, bad_op
//
// One request at a time: req_stall is high from acceptance until the result
// is taken. A node steps through read, drain, write and response states,
// paced by the single store port: one read or one write per cycle. A store
// write skips the read and drain states, a store read the write state.
// After reset a clearing pass writes zero to every entry, with req_stall
// high. A stalled result holds its register and the engine.
// ----------------------------------------------------------------------------
module netlist_node_evaluator_unit
    import nne_pkg::*;
#(
    parameter int SCRATCH_DEPTH = NNE_DEFAULT_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [1:0]            action,
    input  logic [3:0]            node_op,
    input  logic [NNE_REF_W-1:0]  ref_0,
    input  logic [NNE_REF_W-1:0]  ref_1,
    input  logic [NNE_REF_W-1:0]  ref_2,
    input  logic [NNE_REF_W-1:0]  ref_3,
    input  logic [NNE_REF_W-1:0]  ref_4,
    input  logic [NNE_REF_W-1:0]  ref_5,
    input  logic [NNE_REF_W-1:0]  ref_6,
    input  logic [NNE_REF_W-1:0]  ref_7,
    input  logic [NNE_REF_W-1:0]  ref_8,
    input  logic [NNE_WORD_W-1:0] write_value,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic [NNE_WORD_W-1:0] read_data,
    output logic                  bad_op
);

    localparam int AW = $clog2(SCRATCH_DEPTH);

    state_t                state_reg, state_next;
    plan_t                 plan_reg, plan_next;
    logic [3:0]            slot_reg, slot_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic                  pend_reg, pend_next;
    logic                  pend_ok_reg, pend_ok_next;
    logic [3:0]            pend_slot_reg, pend_slot_next;
    logic [NNE_REF_W-1:0]  ref_reg [NNE_NUM_REFS];
    logic [NNE_WORD_W-1:0] a_reg, b_reg, acc_reg;

    logic                  req_take;
    logic [NNE_REF_W-1:0]  ref_sel;
    logic                  ref_ok;
    logic [AW-1:0]         ref_addr;

    logic                  mem_en;
    logic                  mem_we;
    logic [AW-1:0]         mem_addr;
    logic [NNE_WORD_W-1:0] mem_wdata;
    logic [NNE_WORD_W-1:0] mem_rdata;

    alu_ctl_t              alu_ctl;
    logic [NNE_WORD_W-1:0] rd_word;
    logic [NNE_WORD_W-1:0] acc_next;
    logic [NNE_WORD_W-1:0] wr_word;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign res_valid = (state_reg == ST_RESP);
    assign read_data = (plan_reg.kind == K_LOAD) ? a_reg : '0;
    assign bad_op    = plan_reg.bad;

    // operand slot picked by the step counter
    always_comb
    begin
        ref_sel = '0;
        for (int i = 0; i < NNE_NUM_REFS; i++)
        begin
            if (slot_reg == 4'(i))
            begin
                ref_sel = ref_reg[i];
            end
        end
    end

    // negative or out-of-range refs read as disconnected and are never written
    assign ref_ok   = !ref_sel[NNE_REF_W-1] &&
                      (32'(ref_sel[NNE_REF_W-2:0]) < 32'(SCRATCH_DEPTH));
    assign ref_addr = AW'(ref_sel[NNE_REF_W-2:0]);

    assign rd_word  = pend_ok_reg ? mem_rdata : DISC_WORD;

    assign alu_ctl.kind    = plan_reg.kind;
    assign alu_ctl.slot    = pend_reg ? pend_slot_reg : slot_reg;
    assign alu_ctl.rd_last = plan_reg.rd_last;
    assign alu_ctl.wr_last = plan_reg.wr_last;

    nne_alu u_alu
    (
        .ctl      (alu_ctl),
        .op_a     (a_reg),
        .op_b     (b_reg),
        .acc      (acc_reg),
        .rd_word  (rd_word),
        .acc_next (acc_next),
        .wr_word  (wr_word)
    );

    nne_store #(
        .DEPTH (SCRATCH_DEPTH)
    ) u_store
    (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            plan_reg      <= '0;
            slot_reg      <= '0;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_ok_reg   <= 1'b0;
            pend_slot_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            plan_reg      <= plan_next;
            slot_reg      <= slot_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            pend_ok_reg   <= pend_ok_next;
            pend_slot_reg <= pend_slot_next;
        end
    end

    // request payload and operand words
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            ref_reg[0] <= ref_0;
            ref_reg[1] <= ref_1;
            ref_reg[2] <= ref_2;
            ref_reg[3] <= ref_3;
            ref_reg[4] <= ref_4;
            ref_reg[5] <= ref_5;
            ref_reg[6] <= ref_6;
            ref_reg[7] <= ref_7;
            ref_reg[8] <= ref_8;
            a_reg      <= write_value;
            b_reg      <= '0;
            acc_reg    <= '0;
        end
        else if (pend_reg)
        begin
            if (pend_slot_reg == 4'd0)
            begin
                a_reg <= rd_word;
            end
            if (pend_slot_reg == 4'd1)
            begin
                b_reg <= rd_word;
            end
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        plan_next      = plan_reg;
        slot_next      = slot_reg;
        clr_next       = clr_reg;
        pend_next      = 1'b0;
        pend_ok_next   = pend_ok_reg;
        pend_slot_next = pend_slot_reg;
        mem_en         = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = ref_addr;
        mem_wdata      = wr_word;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(SCRATCH_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_take)
                begin
                    plan_next = plan_of(action, node_op);
                    if (plan_next.rd_en)
                    begin
                        state_next = ST_READ;
                        slot_next  = '0;
                    end
                    else if (plan_next.wr_en)
                    begin
                        state_next = ST_WRITE;
                        slot_next  = plan_next.wr_first;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_READ:
            begin
                mem_en         = ref_ok;
                pend_next      = 1'b1;
                pend_ok_next   = ref_ok;
                pend_slot_next = slot_reg;
                if (slot_reg == plan_reg.rd_last)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // last operand word lands this cycle
                if (plan_reg.wr_en)
                begin
                    state_next = ST_WRITE;
                    slot_next  = plan_reg.wr_first;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_WRITE:
            begin
                mem_en = ref_ok;
                mem_we = 1'b1;
                if (slot_reg == plan_reg.wr_last)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            ST_RESP:
            begin
                if (!res_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_store_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_en && mem_we) |-> (state_reg == ST_CLEAR || state_reg == ST_WRITE))
        else $error("store written outside clear or write phase");

    a_capture_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(state_reg == ST_READ))
        else $error("operand capture without a preceding read");

    a_bad_op_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && bad_op) |-> (read_data == '0))
        else $error("bad opcode result carries read data");

    a_read_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (slot_reg <= plan_reg.rd_last))
        else $error("read step beyond last operand slot");

    a_write_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |->
            (slot_reg >= plan_reg.wr_first && slot_reg <= plan_reg.wr_last))
        else $error("write step outside result slots");

endmodule
